/* rtl/skdh_pkg.sv */
// shared types and constants for the string key double hash table
`default_nettype none
package skdh_pkg;
    localparam int unsigned OP_W     = 1;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IDX_W    = 12;
    localparam int unsigned CNT_W    = 12;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned CFG_W    = 17;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned HMUL     = 37;
    localparam logic [CFG_W-1:0] STEP_BASE_RESET = 17'd89989;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'd1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_H1,
        S_STEP,
        S_STEPM,
        S_READ,
        S_CHECK,
        S_STORE,
        S_CLEAR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] key_byte;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
        logic [CNT_W-1:0]    probe_misses;
        logic [CNT_W-1:0]    term_count;
        logic [TOTAL_W-1:0]  collision_total;
    } out_word_t;
endpackage
`default_nettype wire

/* rtl/skdh_if.sv */
// valid/ready channel carrying one word
`default_nettype none
interface skdh_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/string_key_double_hash_table.sv */
// top level: byte-serial key hashing and double hashed probing of slot memories
// usage:
//   in channel carries {opcode, key_byte, last_byte}; one word per key byte
//   out channel carries {status, slot_index, probe_misses, term_count,
//   collision_total}; one word per last-marked input word
//   cfg port: write enable, index (0 slots_in_use, 1 step_base), data
// sequence:
//   an ordinary byte is hashed by the serial mod-M reducer
//   (19 quotient bits); a byte dropped past KEY_BYTES skips the reducer
//   a last byte then runs the h1 and step reductions, then visits
//   key words (memory read, then word compare): a mismatching slot is
//   left at its first differing word, a matching slot compares all
//   KEY_WORDS words, and an insert then writes the KEY_WORDS key words
// reset:
//   a clearing pass over every slot empties the slot length memory; the
//   input is not ready during it (configuration writes are still taken)
// stall:
//   the result waits in an output register; the next word is taken only
//   after the result has left
`default_nettype none
module string_key_double_hash_table import skdh_pkg::*; #(
    parameter int unsigned SLOTS     = 4093,
    parameter int unsigned KEY_BYTES = 29
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    skdh_if.sink                      in_ch,
    skdh_if.source                    out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);
    localparam int unsigned KEY_WORDS = (KEY_BYTES + 7) / 8;
    localparam int unsigned SLOT_W    = $clog2(SLOTS + 1);
    localparam int unsigned ADDR_W    = $clog2(SLOTS);
    localparam int unsigned KW_W      = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int unsigned KADDR_W   = $clog2(SLOTS * KEY_WORDS);
    localparam int unsigned LEN_W     = $clog2(KEY_BYTES + 1);
    localparam int unsigned KB_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int unsigned HN_W      = SLOT_W + 6 + 1;
    localparam int unsigned RED_W     = (SLOT_W > CFG_W) ? SLOT_W : CFG_W;
    localparam int unsigned RN_W      = (HN_W > CFG_W) ? HN_W : CFG_W;

    // memories
    logic [63:0]      key_mem [SLOTS*KEY_WORDS];
    logic [LEN_W-1:0] len_mem [SLOTS];

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   slots_cfg_reg;
    logic [CFG_W-1:0]   step_cfg_reg;
    logic [LEN_W-1:0]   klen_reg;
    logic [SLOT_W-1:0]  hash_reg;
    logic [BYTE_W-1:0]  gather_reg [KEY_BYTES];
    logic               op_reg;
    logic               last_reg;
    logic               keep_reg;
    logic [RN_W-1:0]    hnum_reg;
    logic [SLOT_W-1:0]  m_reg;
    logic [SLOT_W-1:0]  h1_reg;
    logic [SLOT_W-1:0]  step_reg;
    logic [SLOT_W-1:0]  pos_reg;
    logic [SLOT_W:0]    probes_reg;
    logic [KW_W-1:0]    kw_reg;
    logic [LEN_W-1:0]   rdlen_reg;
    logic [63:0]        rdkey_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic [CNT_W-1:0]   terms_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    // effective slot count and base
    logic [SLOT_W-1:0] m_eff;
    logic [CFG_W-1:0]  base_eff;
    always_comb
    begin
        m_eff = (slots_cfg_reg == '0) ? SLOT_W'(1) : SLOT_W'(slots_cfg_reg);
        if (32'(slots_cfg_reg) > SLOTS)
            m_eff = SLOT_W'(SLOTS);
        base_eff = (step_cfg_reg == '0) ? CFG_W'(1) : step_cfg_reg;
    end

    // shared reducer
    logic              red_start, red_busy;
    logic [RN_W-1:0]   red_num;
    logic [RED_W-1:0]  red_den;
    logic [RED_W-1:0]  red_rem;
    skdh_modred #(.NUM_W(RN_W), .DEN_W(RED_W)) u_red (
        .clk(clk), .rst_n(rst_n), .start(red_start), .num(red_num),
        .den(red_den), .busy(red_busy), .rem(red_rem)
    );
    wire red_done = !red_busy && !red_start;

    wire in_acc  = in_ch.valid && in_ch.ready;
    wire out_acc = out_ch.valid && out_ch.ready;
    in_word_t in_w;
    assign in_w = in_ch.data;
    wire keep_byte = (klen_reg < LEN_W'(KEY_BYTES));

    // packed key word of the gathered key
    logic [63:0] key_word;
    always_comb
    begin
        key_word = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (32'(kw_reg) * 8 + b < KEY_BYTES
                && 32'(kw_reg) * 8 + b < 32'(klen_reg))
                key_word[b*8 +: 8] = gather_reg[KB_W'(32'(kw_reg) * 8 + b)];
        end
    end

    logic [SLOT_W:0] pos_sum;
    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    logic [KADDR_W-1:0] kaddr;
    assign kaddr = KADDR_W'(32'(pos_reg) * KEY_WORDS + 32'(kw_reg));
    wire last_kw = (32'(kw_reg) == KEY_WORDS - 1);
    wire word_eq = (rdkey_reg == key_word);
    wire empty_slot = (rdlen_reg == '0);
    wire probes_done = (probes_reg == {1'b0, m_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (32'(clr_reg) == SLOTS - 1) state_next = S_IDLE;
            S_IDLE:  if (in_acc) state_next = S_HASH;
            S_HASH:  if (red_done)
                         state_next = last_reg ? S_H1 : S_IDLE;
            S_H1:    if (red_done) state_next = S_STEP;
            S_STEP:  if (red_done) state_next = S_STEPM;
            S_STEPM: if (red_done) state_next = S_READ;
            S_READ:  state_next = probes_done ? S_OUT : S_CHECK;
            S_CHECK:
            begin
                if (empty_slot)
                    state_next = (op_reg == OP_INSERT) ? S_STORE : S_OUT;
                else if (!word_eq || rdlen_reg != klen_reg)
                    state_next = S_READ;
                else if (last_kw)
                    state_next = S_OUT;
                else
                    state_next = S_READ;
            end
            S_STORE: if (last_kw) state_next = S_OUT;
            S_OUT:   if (out_acc) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // end of a search and the totals it leaves
    wire fin_full  = (state_reg == S_READ) && probes_done;
    wire fin_check = (state_reg == S_CHECK) && (state_next == S_OUT);
    wire fin_store = (state_reg == S_STORE) && last_kw;
    wire finish    = fin_full || fin_check || fin_store;
    logic [CNT_W-1:0]   terms_upd;
    logic [TOTAL_W-1:0] total_upd;
    always_comb
    begin
        terms_upd = terms_reg;
        if (fin_store && terms_reg != '1)
            terms_upd = terms_reg + 1'b1;
        total_upd = total_reg;
        if (finish && op_reg == OP_INSERT)
            total_upd = (33'(total_reg) + 33'(probes_reg) > 33'hFFFFFFFF) ? '1
                        : total_reg + TOTAL_W'(probes_reg);
    end

    // reducer requests
    logic red_go_reg, red_go_next;
    always_comb
    begin
        red_start = red_go_reg;
        red_num   = '0;
        red_den   = RED_W'(m_reg);
        unique case (state_reg)
            S_HASH:  red_num = hnum_reg;
            S_H1:    red_num = RN_W'(hash_reg);
            S_STEP:
            begin
                red_num = RN_W'(h1_reg);
                red_den = RED_W'(base_eff);
            end
            S_STEPM: red_num = hnum_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  red_go_next = in_acc && keep_byte;
            S_HASH:  red_go_next = red_done && last_reg;
            S_H1:    red_go_next = red_done;
            S_STEP:  red_go_next = red_done;
            default: red_go_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            slots_cfg_reg <= 12'd4093;
            step_cfg_reg  <= STEP_BASE_RESET;
            klen_reg      <= '0;
            hash_reg      <= '0;
            terms_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            red_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            red_go_reg <= red_go_next;
            if (cfg_we && cfg_index == REG_SLOTS) slots_cfg_reg <= cfg_data[IDX_W-1:0];
            if (cfg_we && cfg_index == REG_STEP)  step_cfg_reg <= cfg_data;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            // key length and running hash, cleared once the result has left
            if (in_acc && keep_byte)
                klen_reg <= klen_reg + 1'b1;
            else if (out_acc)
                klen_reg <= '0;
            if (state_reg == S_HASH && red_done && keep_reg)
                hash_reg <= SLOT_W'(red_rem);
            else if (out_acc)
                hash_reg <= '0;
            // result valid and running totals
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                terms_reg     <= terms_upd;
                total_reg     <= total_upd;
            end
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= in_w.opcode;
            last_reg <= in_w.last_byte;
            keep_reg <= keep_byte;
            m_reg    <= m_eff;
            hnum_reg <= RN_W'(HN_W'(hash_reg) * HN_W'(HMUL) + HN_W'(in_w.key_byte));
            if (keep_byte) gather_reg[KB_W'(klen_reg)] <= in_w.key_byte;
        end
        if (state_reg == S_H1 && red_done)
        begin
            h1_reg  <= SLOT_W'(red_rem);
            pos_reg <= SLOT_W'(red_rem);
            probes_reg <= '0;
            kw_reg  <= '0;
        end
        // base - h1 mod base, reduced mod m in the next step
        if (state_reg == S_STEP && red_done)
            hnum_reg <= RN_W'(base_eff - red_rem);
        if (state_reg == S_STEPM && red_done)
            step_reg <= (red_rem == '0) ? SLOT_W'(1) : SLOT_W'(red_rem);
        // slot memory read, one key word per visit
        if (state_reg == S_READ)
        begin
            rdlen_reg <= len_mem[ADDR_W'(pos_reg)];
            rdkey_reg <= key_mem[kaddr];
        end
        if (state_reg == S_CHECK && !empty_slot)
        begin
            if (!word_eq || rdlen_reg != klen_reg)
            begin
                kw_reg <= '0;
                probes_reg <= probes_reg + 1'b1;
                pos_reg <= (pos_sum >= {1'b0, m_reg}) ? SLOT_W'(pos_sum - {1'b0, m_reg})
                                                      : pos_sum[SLOT_W-1:0];
            end
            else if (!last_kw)
                kw_reg <= kw_reg + 1'b1;
        end
        if (state_reg == S_STORE)
            kw_reg <= kw_reg + 1'b1;
        if (state_reg == S_CLEAR)
            len_mem[clr_reg] <= '0;
        else if (state_reg == S_CHECK && empty_slot && op_reg == OP_INSERT)
            len_mem[ADDR_W'(pos_reg)] <= klen_reg;
        // key words stored one per cycle
        if (state_reg == S_STORE)
            key_mem[kaddr] <= key_word;
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (fin_full)
        begin
            out_reg.status     <= ST_FULL;
            out_reg.slot_index <= IDX_W'(h1_reg);
        end
        else if (fin_check)
        begin
            out_reg.status     <= empty_slot ? ST_MISSING : ST_FOUND;
            out_reg.slot_index <= IDX_W'(pos_reg);
        end
        else if (fin_store)
        begin
            out_reg.status     <= ST_INSERTED;
            out_reg.slot_index <= IDX_W'(pos_reg);
        end
        if (finish)
        begin
            out_reg.probe_misses <= (probes_reg > (SLOT_W+1)'(12'hFFF)) ? '1
                                                                        : CNT_W'(probes_reg);
            out_reg.term_count      <= terms_upd;
            out_reg.collision_total <= total_upd;
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg && state_reg == S_OUT;
    assign out_ch.data  = out_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ch.ready) else $error("ready during clear");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> probes_reg < {1'b0, m_reg}) else $error("probe overrun");
endmodule
`default_nettype wire

/* rtl/skdh_modred.sv */
// iterative modular reduction: one quotient bit per cycle
`default_nettype none
module skdh_modred import skdh_pkg::*; #(
    parameter int unsigned NUM_W = 24,
    parameter int unsigned DEN_W = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [DEN_W-1:0]      rem
);
    localparam int unsigned CNT_BITS = $clog2(NUM_W + 1);
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DEN_W:0]      rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W:0]      trial;

    // restoring remainder step
    always_comb
    begin
        trial    = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        rem_next = rem_reg;
        num_next = num_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            num_next = num;
            cnt_next = CNT_BITS'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = (trial >= {1'b0, den_reg}) ? trial - {1'b0, den_reg} : trial;
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        if (start)
            den_reg <= den;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg[DEN_W-1:0];
endmodule
`default_nettype wire
